// ----- rtl/lwbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_pkg: shared types and codes of the lru write-back block cache
// Slot count, block width, request/result structs, sequencer states and the
// control structs that pass between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam int SLOTS      = 16;
  localparam int BLOCK_BITS = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  typedef logic [BLOCK_BITS-1:0] blk_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_SYNC  = 2'd2;

  // result actions
  localparam logic [1:0] ACT_DONE  = 2'd0;
  localparam logic [1:0] ACT_WB    = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    blk_t       block_number;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    blk_t       disk_block;
    slot_t      slot;
    logic       hit;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB,
    ST_UPDATE,
    ST_FETCH,
    ST_FINAL,
    ST_SYNC_SCAN,
    ST_SYNC_EMIT
  } state_e;

  // update commands and read index from the sequencer to the slot store
  typedef struct packed {
    logic  touch;
    logic  alloc;
    logic  mark;
    logic  wr_tag;
    logic  clean;
    logic  clr_dirty;
    slot_t slot;
    slot_t rank;
    slot_t dorder;
    blk_t  tag;
    slot_t rd_idx;
  } store_cmd_t;

  // slot store view at the read index, plus occupancy counts
  typedef struct packed {
    blk_t  tag;
    logic  valid;
    logic  dirty;
    slot_t rank;
    slot_t dorder;
    cnt_t  valid_cnt;
    cnt_t  dirty_cnt;
  } store_rd_t;

  typedef struct packed {
    logic  we;
    slot_t addr;
    blk_t  tag;
    slot_t slot;
  } sync_wr_t;

endpackage

// ----- rtl/lru_write_back_block_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_write_back_block_cache_core: tag and policy engine of an lru cache
// Fully associative write-back, write-allocate block cache control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one request:
//   read, write or sync, with a block number. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns the actions for that request in order,
//   the final one flagged by last. A transfer happens when valid is high
//   and stall is low.
//   Each read or write walks all SLOTS slots through one tag comparator,
//   one slot per cycle, before it issues its results. in_stall_o stays
//   high from accept until the last result sits in the output register;
//   then the next request may be accepted while that result still waits.
//   Reset clears all valid and dirty bits at once; the cache starts empty.
//   An output stall holds the current result and pauses the sequencer
//   while it offers one, not in the scan; no result is lost or repeated.
// ----------------------------------------------------------------------------
module lru_write_back_block_cache_core import lwbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  logic       busy;
  logic       res_valid;
  logic       res_ready;
  rsp_t       res;
  store_cmd_t cmd;
  store_rd_t  rd;
  sync_wr_t   sync_wr;
  slot_t      sync_raddr;
  blk_t       sync_tag;
  slot_t      sync_slot;
  logic       out_valid_q;
  rsp_t       out_data_q;

  lwbc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .req_i        (in_data_i),
    .busy_o       (busy),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .cmd_o        (cmd),
    .rd_i         (rd),
    .sync_wr_o    (sync_wr),
    .sync_raddr_o (sync_raddr),
    .sync_tag_i   (sync_tag),
    .sync_slot_i  (sync_slot)
  );

  lwbc_slot_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rd_o   (rd)
  );

  lwbc_sync_order u_sync (
    .clk_i   (clk_i),
    .wr_i    (sync_wr),
    .raddr_i (sync_raddr),
    .tag_o   (sync_tag),
    .slot_o  (sync_slot)
  );

  // output register: a new result loads when the held one is gone or leaves
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer not busy after request transfer");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready && res.last) |=> !in_stall_o)
    else $error("sequencer still busy after last result");

  a_result_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("result offered while idle");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd.dirty_cnt <= rd.valid_cnt) && (rd.valid_cnt <= CNT_W'(SLOTS)))
    else $error("dirty or valid slot count out of range");

endmodule

// ----- rtl/lwbc_slot_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_slot_store: per-slot tag, valid, dirty and rank state
// Holds recency and dirty-order ranks and applies the touch, allocate,
// mark-dirty, clean and clear-dirty updates to all slots in parallel.
// ----------------------------------------------------------------------------
module lwbc_slot_store import lwbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_cmd_t cmd_i,
  output store_rd_t  rd_o
);

  blk_t             tag_q  [SLOTS];
  slot_t            rank_q [SLOTS];
  slot_t            dord_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] dirty_q;
  cnt_t             valid_cnt_q;
  cnt_t             dirty_cnt_q;
  logic             do_mark;

  // a slot that is already dirty keeps its place in the dirty order
  assign do_mark = cmd_i.mark && !dirty_q[cmd_i.slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      valid_cnt_q <= '0;
      dirty_cnt_q <= '0;
    end else begin
      if (cmd_i.alloc) begin
        valid_q[cmd_i.slot] <= 1'b1;
        valid_cnt_q         <= valid_cnt_q + CNT_W'(1);
      end
      if (cmd_i.clr_dirty) begin
        dirty_q     <= '0;
        dirty_cnt_q <= '0;
      end else if (cmd_i.clean) begin
        dirty_q[cmd_i.slot] <= 1'b0;
        dirty_cnt_q         <= dirty_cnt_q - CNT_W'(1);
      end else if (do_mark) begin
        dirty_q[cmd_i.slot] <= 1'b1;
        dirty_cnt_q         <= dirty_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tag) begin
      tag_q[cmd_i.slot] <= cmd_i.tag;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd_i.touch) begin
        if (SLOT_W'(i) == cmd_i.slot) begin
          rank_q[i] <= SLOT_W'(valid_cnt_q - CNT_W'(1));
        end else if (valid_q[i] && (rank_q[i] > cmd_i.rank)) begin
          rank_q[i] <= rank_q[i] - SLOT_W'(1);
        end
      end else if (cmd_i.alloc && (SLOT_W'(i) == cmd_i.slot)) begin
        rank_q[i] <= SLOT_W'(valid_cnt_q);
      end
      if (cmd_i.clean) begin
        if ((SLOT_W'(i) != cmd_i.slot) && dirty_q[i] && (dord_q[i] > cmd_i.dorder)) begin
          dord_q[i] <= dord_q[i] - SLOT_W'(1);
        end
      end else if (do_mark && (SLOT_W'(i) == cmd_i.slot)) begin
        dord_q[i] <= SLOT_W'(dirty_cnt_q);
      end
    end
  end

  always_comb begin
    rd_o.tag       = tag_q[cmd_i.rd_idx];
    rd_o.valid     = valid_q[cmd_i.rd_idx];
    rd_o.dirty     = dirty_q[cmd_i.rd_idx];
    rd_o.rank      = rank_q[cmd_i.rd_idx];
    rd_o.dorder    = dord_q[cmd_i.rd_idx];
    rd_o.valid_cnt = valid_cnt_q;
    rd_o.dirty_cnt = dirty_cnt_q;
  end

endmodule

// ----- rtl/lwbc_sync_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_sync_order: dirty-order buffer for sync
// Filled during the sync scan at each dirty slot's order rank, then read
// back in rank order so write-backs leave oldest dirty first.
// ----------------------------------------------------------------------------
module lwbc_sync_order import lwbc_pkg::*; (
  input  logic     clk_i,
  input  sync_wr_t wr_i,
  input  slot_t    raddr_i,
  output blk_t     tag_o,
  output slot_t    slot_o
);

  blk_t  ord_tag_q  [SLOTS];
  slot_t ord_slot_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      ord_tag_q[wr_i.addr]  <= wr_i.tag;
      ord_slot_q[wr_i.addr] <= wr_i.slot;
    end
  end

  assign tag_o  = ord_tag_q[raddr_i];
  assign slot_o = ord_slot_q[raddr_i];

endmodule

// ----- rtl/lwbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_ctrl: request sequencer with the shared tag comparator
// Walks the slots one per cycle to find hit, free slot and lru victim, or
// to collect dirty slots for sync, then issues updates and results.
// ----------------------------------------------------------------------------
module lwbc_ctrl import lwbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  req_t       req_i,
  output logic       busy_o,
  output logic       res_valid_o,
  output rsp_t       res_o,
  input  logic       res_ready_i,
  output store_cmd_t cmd_o,
  input  store_rd_t  rd_i,
  output sync_wr_t   sync_wr_o,
  output slot_t      sync_raddr_o,
  input  blk_t       sync_tag_i,
  input  slot_t      sync_slot_i
);

  state_e     state_q, state_d;
  logic [1:0] mode_q, mode_d;
  blk_t       bn_q, bn_d;
  slot_t      idx_q, idx_d;
  cnt_t       cnt_q, cnt_d;
  logic       hit_q, hit_d;
  logic       free_q, free_d;
  logic       vic_dirty_q, vic_dirty_d;
  logic       zero_q, zero_d;
  slot_t      hit_slot_q, hit_slot_d;
  slot_t      hit_rank_q, hit_rank_d;
  slot_t      free_slot_q, free_slot_d;
  slot_t      vic_slot_q, vic_slot_d;
  slot_t      vic_dord_q, vic_dord_d;
  blk_t       vic_tag_q, vic_tag_d;
  logic       last_idx;
  logic       tag_eq;
  slot_t      sel_slot;

  assign last_idx = (idx_q == SLOT_W'(SLOTS - 1));
  assign tag_eq   = rd_i.valid && (rd_i.tag == bn_q);
  // hit slot first, then lowest free slot, else the lru victim
  assign sel_slot = hit_q ? hit_slot_q : (free_q ? free_slot_q : vic_slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_dirty_q <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      vic_dirty_q <= vic_dirty_d;
      zero_q      <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    bn_q        <= bn_d;
    hit_slot_q  <= hit_slot_d;
    hit_rank_q  <= hit_rank_d;
    free_slot_q <= free_slot_d;
    vic_slot_q  <= vic_slot_d;
    vic_dord_q  <= vic_dord_d;
    vic_tag_q   <= vic_tag_d;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    bn_d        = bn_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    free_d      = free_q;
    vic_dirty_d = vic_dirty_q;
    zero_d      = zero_q;
    hit_slot_d  = hit_slot_q;
    hit_rank_d  = hit_rank_q;
    free_slot_d = free_slot_q;
    vic_slot_d  = vic_slot_q;
    vic_dord_d  = vic_dord_q;
    vic_tag_d   = vic_tag_q;

    busy_o      = (state_q != ST_IDLE);
    res_valid_o = 1'b0;
    res_o       = '0;

    cmd_o        = '0;
    cmd_o.slot   = sel_slot;
    cmd_o.rank   = hit_q ? hit_rank_q : '0;
    cmd_o.dorder = vic_dord_q;
    cmd_o.tag    = bn_q;
    cmd_o.rd_idx = idx_q;

    sync_wr_o      = '0;
    sync_wr_o.addr = rd_i.dorder;
    sync_wr_o.tag  = rd_i.tag;
    sync_wr_o.slot = idx_q;
    sync_raddr_o   = cnt_q[SLOT_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d      = req_i.mode;
          bn_d        = req_i.block_number;
          idx_d       = '0;
          cnt_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          vic_dirty_d = 1'b0;
          if (req_i.mode == MODE_SYNC) begin
            zero_d  = 1'b1;
            state_d = ST_SYNC_SCAN;
          end else if ((req_i.mode == MODE_READ) || (req_i.mode == MODE_WRITE)) begin
            zero_d  = 1'b0;
            state_d = ST_SCAN;
          end else begin
            // unused mode: a lone done result
            zero_d  = 1'b1;
            state_d = ST_FINAL;
          end
        end
      end
      ST_SCAN: begin
        if (tag_eq && !hit_q) begin
          hit_d      = 1'b1;
          hit_slot_d = idx_q;
          hit_rank_d = rd_i.rank;
        end
        if (!rd_i.valid && !free_q) begin
          free_d      = 1'b1;
          free_slot_d = idx_q;
        end
        if (rd_i.valid && (rd_i.rank == '0)) begin
          vic_slot_d  = idx_q;
          vic_tag_d   = rd_i.tag;
          vic_dirty_d = rd_i.dirty;
          vic_dord_d  = rd_i.dorder;
        end
        idx_d = idx_q + SLOT_W'(1);
        if (last_idx) begin
          state_d = (!hit_d && !free_d && vic_dirty_d) ? ST_WB : ST_UPDATE;
        end
      end
      ST_WB: begin
        res_valid_o       = 1'b1;
        res_o.action      = ACT_WB;
        res_o.disk_block  = vic_tag_q;
        res_o.slot        = vic_slot_q;
        if (res_ready_i) begin
          cmd_o.clean = 1'b1;
          state_d     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.touch  = hit_q || !free_q;
        cmd_o.alloc  = !hit_q && free_q;
        cmd_o.mark   = (mode_q == MODE_WRITE);
        cmd_o.wr_tag = !hit_q;
        state_d      = (!hit_q && (mode_q == MODE_READ)) ? ST_FETCH : ST_FINAL;
      end
      ST_FETCH: begin
        res_valid_o      = 1'b1;
        res_o.action     = ACT_FETCH;
        res_o.disk_block = bn_q;
        res_o.slot       = sel_slot;
        if (res_ready_i) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        res_valid_o      = 1'b1;
        res_o.action     = ACT_DONE;
        res_o.disk_block = zero_q ? '0 : bn_q;
        res_o.slot       = zero_q ? '0 : sel_slot;
        res_o.hit        = hit_q;
        res_o.last       = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_SYNC_SCAN: begin
        sync_wr_o.we = rd_i.dirty;
        idx_d        = idx_q + SLOT_W'(1);
        if (last_idx) begin
          state_d = ST_SYNC_EMIT;
        end
      end
      ST_SYNC_EMIT: begin
        if (cnt_q == rd_i.dirty_cnt) begin
          cmd_o.clr_dirty = 1'b1;
          state_d         = ST_FINAL;
        end else begin
          res_valid_o      = 1'b1;
          res_o.action     = ACT_WB;
          res_o.disk_block = sync_tag_i;
          res_o.slot       = sync_slot_i;
          if (res_ready_i) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
